>>> rtl/bitplane_step_distributor_defines.svh
// Assertion macros shared by the bitplane step distributor RTL.
// Depends on a clock named clk and a synchronous reset named rst in the including scope.
`ifndef BITPLANE_STEP_DISTRIBUTOR_DEFINES_SVH
`define BITPLANE_STEP_DISTRIBUTOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define BSD_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bitplane_step_distributor: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define BSD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bitplane_step_distributor: next-cycle check failed");

`endif

>>> rtl/bsd_pkg.sv
// Package for the bitplane step distributor: sizes, request codes, shared types
// and the bit-plane helper functions. Used by every module of the block.
package bsd_pkg;

  localparam int AXES       = 4;
  localparam int COUNT_BITS = 8;
  localparam int INDEX_W    = COUNT_BITS;
  localparam int DEPTH_W    = $clog2(COUNT_BITS + 1);
  localparam int PLANE_W    = (COUNT_BITS > 1) ? $clog2(COUNT_BITS) : 1;

  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_TICK = 1'b1
  } action_t;

  typedef logic [AXES-1:0][COUNT_BITS-1:0] counts_t;

  typedef struct packed {
    logic [AXES-1:0] step_mask;
    logic [AXES-1:0] dir_out;
    logic            segment_end;
    logic            idle;
    logic            load_accepted;
  } res_t;

  typedef struct packed {
    logic run_active;
    logic next_valid;
  } status_t;

  // Bit length of a count word; the OR of all counts has the bit length of the largest.
  function automatic logic [DEPTH_W-1:0] bit_length(input logic [COUNT_BITS-1:0] v);
    logic [DEPTH_W-1:0] len;
    len = '0;
    for (int i = 0; i < COUNT_BITS; i++) begin
      if (v[i]) begin
        len = DEPTH_W'(i + 1);
      end
    end
    return len;
  endfunction

  // Trailing zero count; zero for an all-zero word.
  function automatic logic [DEPTH_W-1:0] trailing_zeros(input logic [INDEX_W-1:0] v);
    logic [DEPTH_W-1:0] tz;
    logic               found;
    tz    = '0;
    found = 1'b0;
    for (int i = 0; i < INDEX_W; i++) begin
      if (!found && v[i]) begin
        tz    = DEPTH_W'(i);
        found = 1'b1;
      end
    end
    return tz;
  endfunction

  // Index of the last tick of a segment: 2^depth - 2.
  function automatic logic [INDEX_W-1:0] last_index(input logic [DEPTH_W-1:0] depth);
    logic [INDEX_W:0] span;
    span = (INDEX_W + 1)'(1) << depth;
    return INDEX_W'(span - (INDEX_W + 1)'(2));
  endfunction

endpackage

>>> rtl/bitplane_step_distributor.sv
// Bitplane step distributor: takes one load or tick request per cycle. Each request
// is worked in one pass of logic from the segment state into an output register (or its
// skid entry while the register holds an untaken result). in_stall rises only when both the
// output register and its single skid entry hold results not yet taken; with out_stall
// low the block sustains one request per cycle. Loads are refused (load_accepted = 0)
// while a pending segment is already stored. There is no clearing pass after reset.
`include "bitplane_step_distributor_defines.svh"

module bitplane_step_distributor (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              action,
  input  logic [bsd_pkg::COUNT_BITS-1:0]    dist_axis0,
  input  logic [bsd_pkg::COUNT_BITS-1:0]    dist_axis1,
  input  logic [bsd_pkg::COUNT_BITS-1:0]    dist_axis2,
  input  logic [bsd_pkg::COUNT_BITS-1:0]    dist_axis3,
  input  logic [bsd_pkg::AXES-1:0]          dir_in,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [bsd_pkg::AXES-1:0]          step_mask,
  output logic [bsd_pkg::AXES-1:0]          dir_out,
  output logic                              segment_end,
  output logic                              idle,
  output logic                              load_accepted
);

  logic              in_acc;
  logic              buf_full;
  bsd_pkg::counts_t  dist_in;
  bsd_pkg::res_t     core_res;
  bsd_pkg::res_t     out_res;
  bsd_pkg::status_t  status;

  assign dist_in[0] = dist_axis0;
  assign dist_in[1] = dist_axis1;
  assign dist_in[2] = dist_axis2;
  assign dist_in[3] = dist_axis3;

  assign in_stall = buf_full;
  assign in_acc   = in_valid && !buf_full;

  bsd_core u_core (
    .clk     (clk),
    .rst     (rst),
    .push    (in_acc),
    .action  (action),
    .dist_in (dist_in),
    .dir_in  (dir_in),
    .res     (core_res),
    .status  (status)
  );

  bsd_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (in_acc),
    .push_res  (core_res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign step_mask     = out_res.step_mask;
  assign dir_out       = out_res.dir_out;
  assign segment_end   = out_res.segment_end;
  assign idle          = out_res.idle;
  assign load_accepted = out_res.load_accepted;

  `BSD_ASSERT_SAME(a_idle_empty, out_valid && idle, (step_mask == '0) && !segment_end && !load_accepted)
  `BSD_ASSERT_NEXT(a_load_fills, in_acc && (action == bsd_pkg::ACT_LOAD) && !status.next_valid, status.next_valid)
  `BSD_ASSERT_NEXT(a_tick_swaps, in_acc && (action == bsd_pkg::ACT_TICK) && !status.run_active && status.next_valid, !status.next_valid)

endmodule

>>> rtl/bsd_core.sv
// Segment state and the single-pass step logic of the bitplane step distributor.
// Depends on bsd_pkg; produces one result per accepted request.
module bsd_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  logic                         action,
  input  bsd_pkg::counts_t             dist_in,
  input  logic [bsd_pkg::AXES-1:0]     dir_in,
  output bsd_pkg::res_t                res,
  output bsd_pkg::status_t             status
);

  bsd_pkg::counts_t                      run_counts, run_counts_next;
  logic [bsd_pkg::AXES-1:0]              run_dir, run_dir_next;
  logic [bsd_pkg::DEPTH_W-1:0]           run_depth, run_depth_next;
  logic [bsd_pkg::INDEX_W-1:0]           tick_index, tick_index_next;
  logic                                  run_active, run_active_next;
  logic                                  next_valid, next_valid_next;
  bsd_pkg::counts_t                      next_counts;
  logic [bsd_pkg::AXES-1:0]              next_dir;
  logic                                  store_pending;

  logic [bsd_pkg::COUNT_BITS-1:0]        all_bits;
  logic [bsd_pkg::DEPTH_W-1:0]           depth, tz, plane_wide;
  logic [bsd_pkg::PLANE_W-1:0]           plane;
  logic [bsd_pkg::INDEX_W-1:0]           index_plus;

  always_comb begin
    run_counts_next = run_counts;
    run_dir_next    = run_dir;
    run_depth_next  = run_depth;
    tick_index_next = tick_index;
    run_active_next = run_active;
    next_valid_next = next_valid;
    store_pending   = 1'b0;
    res             = '0;
    all_bits        = '0;
    depth           = '0;
    tz              = '0;
    plane_wide      = '0;
    plane           = '0;
    index_plus      = '0;

    if (action == bsd_pkg::ACT_LOAD) begin
      if (!next_valid) begin
        store_pending     = 1'b1;
        next_valid_next   = 1'b1;
        res.load_accepted = 1'b1;
      end
    end else begin
      if (!run_active && next_valid) begin
        for (int i = 0; i < bsd_pkg::AXES; i++) begin
          all_bits = all_bits | next_counts[i];
        end
        run_counts_next = next_counts;
        run_dir_next    = next_dir;
        run_depth_next  = bsd_pkg::bit_length(all_bits);
        if (run_depth_next == '0) begin
          run_depth_next = bsd_pkg::DEPTH_W'(1);
        end
        tick_index_next = '0;
        run_active_next = 1'b1;
        next_valid_next = 1'b0;
      end
      if (!run_active_next) begin
        res.idle = 1'b1;
      end else begin
        depth = run_depth_next;
        if (depth == '0) begin
          depth = bsd_pkg::DEPTH_W'(1);
        end
        if (depth > bsd_pkg::DEPTH_W'(bsd_pkg::COUNT_BITS)) begin
          depth = bsd_pkg::DEPTH_W'(bsd_pkg::COUNT_BITS);
        end
        index_plus = tick_index_next + bsd_pkg::INDEX_W'(1);
        tz         = bsd_pkg::trailing_zeros(index_plus);
        if (tz < depth) begin
          plane_wide = depth - bsd_pkg::DEPTH_W'(1) - tz;
        end
        plane = bsd_pkg::PLANE_W'(plane_wide);
        for (int i = 0; i < bsd_pkg::AXES; i++) begin
          res.step_mask[i] = run_counts_next[i][plane];
        end
        if (tick_index_next >= bsd_pkg::last_index(depth)) begin
          res.segment_end = 1'b1;
          run_active_next = 1'b0;
          tick_index_next = '0;
        end else begin
          tick_index_next = index_plus;
        end
      end
    end
    res.dir_out = run_dir_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_counts <= '0;
      run_dir    <= '0;
      run_depth  <= '0;
      tick_index <= '0;
      run_active <= 1'b0;
      next_valid <= 1'b0;
    end else if (push) begin
      run_counts <= run_counts_next;
      run_dir    <= run_dir_next;
      run_depth  <= run_depth_next;
      tick_index <= tick_index_next;
      run_active <= run_active_next;
      next_valid <= next_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push && store_pending) begin
      next_counts <= dist_in;
      next_dir    <= dir_in;
    end
  end

  assign status.run_active = run_active;
  assign status.next_valid = next_valid;

endmodule

>>> rtl/bsd_out_buf.sv
// Output register with one skid entry for the bitplane step distributor.
// Depends on bsd_pkg for the result type.
module bsd_out_buf (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  bsd_pkg::res_t  push_res,
  output logic           full,
  output logic           out_valid,
  input  logic           out_stall,
  output bsd_pkg::res_t  out_res
);

  logic          main_valid;
  logic          skid_valid;
  bsd_pkg::res_t main_res;
  bsd_pkg::res_t skid_res;
  logic          pop;

  assign pop = main_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (main_valid && !pop) begin
        skid_valid <= 1'b1;
      end else begin
        main_valid <= 1'b1;
      end
    end else if (pop) begin
      main_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        main_res <= skid_res;
      end
    end else if (push) begin
      if (main_valid && !pop) begin
        skid_res <= push_res;
      end else begin
        main_res <= push_res;
      end
    end
  end

  assign full      = skid_valid;
  assign out_valid = main_valid;
  assign out_res   = main_res;

endmodule
